// ===== rtl/hsd_pkg.sv =====
// Shared types, widths and node sign table for the hex20 shape derivative block.
package hsd_pkg;

  // Field widths of the beats.
  localparam int COORD_W      = 16;
  localparam int DERIV_W      = 17;
  localparam int NODE_W       = 5;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 56;
  localparam int OUT_PAD_W    = OUT_TDATA_W - 3 * DERIV_W;

  // Element layout.
  localparam int NODE_COUNT   = 20;
  localparam int CORNER_COUNT = 8;
  localparam int AXIS_COUNT   = 3;
  localparam logic [NODE_W-1:0] LAST_NODE   = NODE_W'(NODE_COUNT - 1);
  localparam logic [NODE_W-1:0] CORNER_LIM  = NODE_W'(CORNER_COUNT);

  // Default fixed point format.
  localparam int FRAC_BITS_DEF = 14;

  // Saturation limits of a derivative, as magnitudes and as output codes.
  localparam int DERIV_POS_LIM = 65535;
  localparam int DERIV_NEG_LIM = 65536;
  localparam logic [DERIV_W-1:0] DERIV_POS_SAT = 17'h0FFFF;
  localparam logic [DERIV_W-1:0] DERIV_NEG_SAT = 17'h10000;

  // Natural coordinate sign of a node along one axis.
  typedef enum logic [1:0] {
    SG_ZERO,
    SG_POS,
    SG_NEG
  } sign_t;

  // Per-node signs along r, s and t; a zero marks the axis of a mid-edge node.
  localparam sign_t NODE_SIGN [NODE_COUNT][AXIS_COUNT] = '{
    '{SG_NEG,  SG_NEG,  SG_NEG }, '{SG_POS,  SG_NEG,  SG_NEG },
    '{SG_POS,  SG_POS,  SG_NEG }, '{SG_NEG,  SG_POS,  SG_NEG },
    '{SG_NEG,  SG_NEG,  SG_POS }, '{SG_POS,  SG_NEG,  SG_POS },
    '{SG_POS,  SG_POS,  SG_POS }, '{SG_NEG,  SG_POS,  SG_POS },
    '{SG_ZERO, SG_NEG,  SG_NEG }, '{SG_POS,  SG_ZERO, SG_NEG },
    '{SG_ZERO, SG_POS,  SG_NEG }, '{SG_NEG,  SG_ZERO, SG_NEG },
    '{SG_ZERO, SG_NEG,  SG_POS }, '{SG_POS,  SG_ZERO, SG_POS },
    '{SG_ZERO, SG_POS,  SG_POS }, '{SG_NEG,  SG_ZERO, SG_POS },
    '{SG_NEG,  SG_NEG,  SG_ZERO}, '{SG_POS,  SG_NEG,  SG_ZERO},
    '{SG_POS,  SG_POS,  SG_ZERO}, '{SG_NEG,  SG_POS,  SG_ZERO}
  };

  // Load enables of the four arithmetic stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

// ===== rtl/hex20_shape_derivatives_top.sv =====
// Path: the first node of a point passes the sequencer, stages 1 to 4 and the output register.
// Throughput: one result beat per cycle while nothing stalls; the node sequencer issues
// one node a cycle, when not stalled, into a 4-stage product pipeline plus output register.
// A new point is accepted in the cycle its predecessor's last node issues.
// Reset (rst_n low, synchronous) empties the sequencer and all stage valid bits.
module hex20_shape_derivatives_top #(
  parameter int FRAC_BITS = hsd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // coord_r [15:0], coord_s [31:16], coord_t [47:32]
  input  logic [hsd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // deriv_r [16:0], deriv_s [33:17], deriv_t [50:34], zero [55:51]
  output logic [hsd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // node_index [4:0]
  output logic [hsd_pkg::NODE_W-1:0]         out_tuser,
  output logic                               out_tlast
);
  import hsd_pkg::*;

  logic                      iss_valid;
  logic [NODE_W-1:0]         iss_node;
  logic signed [COORD_W-1:0] iss_r, iss_s, iss_t;
  logic [4:1]                v_r;
  logic [4:1]                rdy;
  logic [NODE_W-1:0]         node_r [1:4];
  logic                      out_rdy;
  pipe_en_t                  en;
  logic [DERIV_W-1:0]        deriv [AXIS_COUNT];
  logic                      out_tvalid_r, out_tlast_r;
  logic [NODE_W-1:0]         out_tuser_r;
  logic [DERIV_W-1:0]        out_dr_r, out_ds_r, out_dt_r;

  hsd_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_coord_r  (in_tdata[COORD_W-1:0]),
    .in_coord_s  (in_tdata[2*COORD_W-1:COORD_W]),
    .in_coord_t  (in_tdata[3*COORD_W-1:2*COORD_W]),
    .iss_ready   (rdy[1]),
    .iss_valid   (iss_valid),
    .iss_node    (iss_node),
    .iss_coord_r (iss_r),
    .iss_coord_s (iss_s),
    .iss_coord_t (iss_t)
  );

  // A stage moves on when it is empty or the stage after it moves on.
  assign out_rdy = !out_tvalid_r || out_tready;
  assign rdy[4]  = !v_r[4] || out_rdy;
  assign rdy[3]  = !v_r[3] || rdy[4];
  assign rdy[2]  = !v_r[2] || rdy[3];
  assign rdy[1]  = !v_r[1] || rdy[2];

  assign en.s1 = iss_valid && rdy[1];
  assign en.s2 = v_r[1] && rdy[2];
  assign en.s3 = v_r[2] && rdy[3];
  assign en.s4 = v_r[3] && rdy[4];

  // One lane per derivative axis.
  for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_lane
    hsd_lane #(
      .FRAC_BITS (FRAC_BITS),
      .AXIS      (a)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .node    (iss_node),
      .coord_r (iss_r),
      .coord_s (iss_s),
      .coord_t (iss_t),
      .deriv   (deriv[a])
    );
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (rdy[1]) v_r[1] <= iss_valid;
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
      if (out_rdy) out_tvalid_r <= v_r[4];
    end
  end

  // Node index travels alongside the lanes.
  always_ff @(posedge clk) begin
    if (en.s1) node_r[1] <= iss_node;
    if (en.s2) node_r[2] <= node_r[1];
    if (en.s3) node_r[3] <= node_r[2];
    if (en.s4) node_r[4] <= node_r[3];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (v_r[4] && out_rdy) begin
      out_tuser_r <= node_r[4];
      out_tlast_r <= (node_r[4] == LAST_NODE);
      out_dr_r    <= deriv[0];
      out_ds_r    <= deriv[1];
      out_dt_r    <= deriv[2];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_dt_r, out_ds_r, out_dr_r};

endmodule

// ===== rtl/hsd_seq.sv =====
// Node sequencer: holds one point and issues its twenty nodes, one per cycle while iss_ready is high.
module hsd_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic signed [hsd_pkg::COORD_W-1:0] in_coord_r,
  input  logic signed [hsd_pkg::COORD_W-1:0] in_coord_s,
  input  logic signed [hsd_pkg::COORD_W-1:0] in_coord_t,
  input  logic                          iss_ready,
  output logic                          iss_valid,
  output logic [hsd_pkg::NODE_W-1:0]    iss_node,
  output logic signed [hsd_pkg::COORD_W-1:0] iss_coord_r,
  output logic signed [hsd_pkg::COORD_W-1:0] iss_coord_s,
  output logic signed [hsd_pkg::COORD_W-1:0] iss_coord_t
);
  import hsd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic signed [COORD_W-1:0] cr_r, cs_r, ct_r;
  logic              fire;
  logic              accept;

  // A new point is taken while the last node of the current one issues.
  assign fire      = busy_r && iss_ready;
  assign in_tready = !busy_r || (fire && (node_r == LAST_NODE));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    busy_nxt = busy_r;
    node_nxt = node_r;
    if (accept) begin
      busy_nxt = 1'b1;
      node_nxt = '0;
    end else if (fire) begin
      if (node_r == LAST_NODE) begin
        busy_nxt = 1'b0;
        node_nxt = '0;
      end else begin
        node_nxt = node_r + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      node_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      node_r <= node_nxt;
    end
  end

  // The point itself is payload and is only captured on an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      cr_r <= in_coord_r;
      cs_r <= in_coord_s;
      ct_r <= in_coord_t;
    end
  end

  assign iss_valid   = busy_r;
  assign iss_node    = node_r;
  assign iss_coord_r = cr_r;
  assign iss_coord_s = cs_r;
  assign iss_coord_t = ct_r;

endmodule

// ===== rtl/hsd_lane.sv =====
// One derivative lane: operand forming, two-step triple product, rounding and clamping.
module hsd_lane #(
  parameter int FRAC_BITS = hsd_pkg::FRAC_BITS_DEF,
  parameter int AXIS      = 0
) (
  input  logic                               clk,
  input  hsd_pkg::pipe_en_t                  en,
  input  logic [hsd_pkg::NODE_W-1:0]         node,
  input  logic signed [hsd_pkg::COORD_W-1:0] coord_r,
  input  logic signed [hsd_pkg::COORD_W-1:0] coord_s,
  input  logic signed [hsd_pkg::COORD_W-1:0] coord_t,
  output logic [hsd_pkg::DERIV_W-1:0]        deriv
);
  import hsd_pkg::*;

  // Operand magnitudes do not exceed 2^17 + 2^FRAC_BITS.
  localparam int MW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int SW = MW + 1;
  localparam int PW = 3 * MW + 1;
  localparam int IA = (AXIS + 1) % 3;
  localparam int IB = (AXIS + 2) % 3;
  localparam int SH_CORNER = 2 * FRAC_BITS + 3;
  localparam int SH_EDGE   = 2 * FRAC_BITS + 2;
  localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;
  localparam logic [PW-1:0] HALF_CORNER = PW'(1) << (SH_CORNER - 1);
  localparam logic [PW-1:0] HALF_EDGE   = PW'(1) << (SH_EDGE - 1);

  function automatic logic signed [SW-1:0] apply_sign(input sign_t g,
                                                      input logic signed [SW-1:0] v);
    case (g)
      SG_POS:  apply_sign = v;
      SG_NEG:  apply_sign = -v;
      default: apply_sign = '0;
    endcase
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] a;
    a   = (v < 0) ? -v : v;
    mag = a[MW-1:0];
  endfunction

  logic signed [SW-1:0] xv [AXIS_COUNT];
  sign_t gd, ga, gb, go;
  logic signed [SW-1:0] xd, xa, xb, xe, xo;
  logic signed [SW-1:0] op0, op1, op2, inner;
  logic                 corner;

  assign xv[0] = SW'(coord_r);
  assign xv[1] = SW'(coord_s);
  assign xv[2] = SW'(coord_t);

  // Stage 1 inputs: the three signed factors of this node's derivative.
  always_comb begin
    gd     = NODE_SIGN[node][AXIS];
    ga     = NODE_SIGN[node][IA];
    gb     = NODE_SIGN[node][IB];
    xd     = xv[AXIS];
    xa     = xv[IA];
    xb     = xv[IB];
    corner = (node < CORNER_LIM);
    xe     = (ga == SG_ZERO) ? xa : xb;
    xo     = (ga == SG_ZERO) ? xb : xa;
    go     = (ga == SG_ZERO) ? gb : ga;
    inner  = apply_sign(ga, xa) + apply_sign(gb, xb) - ONE;
    if (corner) begin
      op0 = ONE + apply_sign(ga, xa);
      op1 = ONE + apply_sign(gb, xb);
      op2 = (xd <<< 1) + apply_sign(gd, inner);
    end else if (gd == SG_ZERO) begin
      op0 = -(xd <<< 1);
      op1 = ONE + apply_sign(ga, xa);
      op2 = ONE + apply_sign(gb, xb);
    end else begin
      op0 = apply_sign(gd, ONE - xe);
      op1 = ONE + xe;
      op2 = ONE + apply_sign(go, xo);
    end
  end

  // Stage 1: sign of the product and factor magnitudes.
  logic          neg1_r, corner1_r;
  logic [MW-1:0] m0_r, m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      neg1_r    <= (op0 < 0) ^ (op1 < 0) ^ (op2 < 0);
      corner1_r <= corner;
      m0_r      <= mag(op0);
      m1_r      <= mag(op1);
      m2_r      <= mag(op2);
    end
  end

  // Stage 2: product of the first two factors.
  logic            neg2_r, corner2_r;
  logic [2*MW-1:0] ab_r, ab_nxt;
  logic [MW-1:0]   m2b_r;

  assign ab_nxt = (2 * MW)'(m0_r) * (2 * MW)'(m1_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      neg2_r    <= neg1_r;
      corner2_r <= corner1_r;
      ab_r      <= ab_nxt;
      m2b_r     <= m2_r;
    end
  end

  // Stage 3: third factor against the low and high halves of the pair product.
  logic            neg3_r, corner3_r;
  logic [2*MW-1:0] plo_r, phi_r, plo_nxt, phi_nxt;

  assign plo_nxt = (2 * MW)'(ab_r[MW-1:0]) * (2 * MW)'(m2b_r);
  assign phi_nxt = (2 * MW)'(ab_r[2*MW-1:MW]) * (2 * MW)'(m2b_r);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg3_r    <= neg2_r;
      corner3_r <= corner2_r;
      plo_r     <= plo_nxt;
      phi_r     <= phi_nxt;
    end
  end

  // Stage 4: full magnitude plus the rounding half.
  logic          neg4_r, corner4_r;
  logic [PW-1:0] sum_r, sum_nxt;

  assign sum_nxt = PW'(plo_r) + (PW'(phi_r) << MW) + (corner3_r ? HALF_CORNER : HALF_EDGE);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      neg4_r    <= neg3_r;
      corner4_r <= corner3_r;
      sum_r     <= sum_nxt;
    end
  end

  // Scale, clamp to the 17-bit range and restore the sign.
  logic [PW-1:0]      q;
  logic [DERIV_W-1:0] q_lo;

  always_comb begin
    q    = corner4_r ? (sum_r >> SH_CORNER) : (sum_r >> SH_EDGE);
    q_lo = q[DERIV_W-1:0];
    if (neg4_r) begin
      deriv = (q > PW'(DERIV_NEG_LIM)) ? DERIV_NEG_SAT : (~q_lo + DERIV_W'(1));
    end else begin
      deriv = (q > PW'(DERIV_POS_LIM)) ? DERIV_POS_SAT : q_lo;
    end
  end

endmodule

// ===== rtl/hsd_checker.sv =====
// Port-level checks for the hex20 shape derivative block, bound to its top level.
module hsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [hsd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [hsd_pkg::NODE_W-1:0]      out_tuser,
  input logic                            out_tlast
);
  import hsd_pkg::*;

  // Reset leaves no result beat on offer.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat offered straight after reset");

  // The last flag sits on node 19 and on no other node.
  a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == LAST_NODE)))
    else $error("last flag and node index disagree");

  // A point occupies the sequencer until its last node issues, so no beat follows at once.
  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in two consecutive cycles");

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // Padding bits above the three derivatives stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:3*DERIV_W] == '0))
    else $error("padding bits of result beat not zero");

endmodule

bind hex20_shape_derivatives_top hsd_checker u_hsd_checker (.*);
